// ===== rtl/core/kpd_pkg.sv =====
// Shared types, constants and register codes of the keypad scanner.
`default_nettype none

package kpd_pkg;

  localparam int MAP_SPAN = 8;
  localparam int MAX_ROWS = 8;
  localparam int MAX_COLS = 8;
  localparam int ROW_LIMIT = (MAX_ROWS < MAP_SPAN) ? MAX_ROWS : MAP_SPAN;
  localparam int COL_LIMIT = (MAX_COLS < MAP_SPAN) ? MAX_COLS : MAP_SPAN;

  localparam int MAP_W = 64;
  localparam int TIME_W = 32;
  localparam int COUNT_W = 4;
  localparam int DEB_W = 8;
  localparam int CODE_W = 8;
  localparam int POS_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  typedef logic [CODE_W-1:0] code_t;

  localparam code_t NO_KEY_CODE = 8'hFF;

  localparam logic [COUNT_W-1:0] ROW_COUNT_RST = 4'd4;
  localparam logic [COUNT_W-1:0] COL_COUNT_RST = 4'd4;
  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT   = 2'd0,
    REG_COL_COUNT   = 2'd1,
    REG_DEBOUNCE_MS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [COUNT_W-1:0] row_count;
    logic [COUNT_W-1:0] col_count;
    logic [DEB_W-1:0]   debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    code_t            code;
  } scan_t;

endpackage

`default_nettype wire

// ===== rtl/core/kpd_if.sv =====
// Channel interfaces of the keypad scanner: scan input, result output, register writes.
`default_nettype none

interface kpd_in_if;
  logic                         valid;
  logic                         ready;
  logic [kpd_pkg::MAP_W-1:0]    pressed_map;
  logic [kpd_pkg::TIME_W-1:0]   now_ms;

  modport source (output valid, output pressed_map, output now_ms, input ready);
  modport sink (input valid, input pressed_map, input now_ms, output ready);
endinterface

interface kpd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         raw_found;
  logic [kpd_pkg::POS_W-1:0]    raw_row;
  logic [kpd_pkg::POS_W-1:0]    raw_col;
  logic                         new_key;
  logic [kpd_pkg::CODE_W-1:0]   key_code;

  modport source (output valid, output raw_found, output raw_row, output raw_col,
                  output new_key, output key_code, input ready);
  modport sink (input valid, input raw_found, input raw_row, input raw_col,
                input new_key, input key_code, output ready);
endinterface

interface kpd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [kpd_pkg::CFG_IDX_W-1:0]    index;
  logic [kpd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kpd_scan.sv =====
// Priority encoder: lowest pressed row, then lowest pressed column, within the scanned area.
`default_nettype none

module kpd_scan (
  input  wire logic [kpd_pkg::MAP_W-1:0] pressed_map,
  input  wire kpd_pkg::cfg_t             cfg,
  output kpd_pkg::scan_t                 scan
);

  logic [kpd_pkg::COUNT_W-1:0]  rows_eff;
  logic [kpd_pkg::COUNT_W-1:0]  cols_eff;
  logic [kpd_pkg::MAP_SPAN-1:0] col_mask;
  logic [kpd_pkg::MAP_SPAN-1:0] row_hit;
  logic [kpd_pkg::MAP_SPAN-1:0] sel_bits;
  logic                         row_found;
  logic [kpd_pkg::POS_W-1:0]    row_idx;
  logic [kpd_pkg::POS_W-1:0]    col_idx;

  // Clamp the counts to what the matrix and the bitmap hold.
  always_comb begin
    rows_eff = (cfg.row_count > kpd_pkg::COUNT_W'(kpd_pkg::ROW_LIMIT)) ?
               kpd_pkg::COUNT_W'(kpd_pkg::ROW_LIMIT) : cfg.row_count;
    cols_eff = (cfg.col_count > kpd_pkg::COUNT_W'(kpd_pkg::COL_LIMIT)) ?
               kpd_pkg::COUNT_W'(kpd_pkg::COL_LIMIT) : cfg.col_count;
  end

  always_comb begin
    for (int c = 0; c < kpd_pkg::MAP_SPAN; c++) begin
      col_mask[c] = (kpd_pkg::COUNT_W'(c) < cols_eff);
    end
    for (int r = 0; r < kpd_pkg::MAP_SPAN; r++) begin
      row_hit[r] = (kpd_pkg::COUNT_W'(r) < rows_eff) &&
                   (|(pressed_map[r*kpd_pkg::MAP_SPAN +: kpd_pkg::MAP_SPAN] & col_mask));
    end
  end

  // Walk down so the lowest hit wins.
  always_comb begin
    row_found = |row_hit;
    row_idx = '0;
    for (int r = kpd_pkg::MAP_SPAN - 1; r >= 0; r--) begin
      if (row_hit[r]) begin
        row_idx = kpd_pkg::POS_W'(r);
      end
    end
    sel_bits = pressed_map[row_idx*kpd_pkg::MAP_SPAN +: kpd_pkg::MAP_SPAN] & col_mask;
    col_idx = '0;
    for (int c = kpd_pkg::MAP_SPAN - 1; c >= 0; c--) begin
      if (sel_bits[c]) begin
        col_idx = kpd_pkg::POS_W'(c);
      end
    end
  end

  always_comb begin
    scan.found = row_found;
    scan.row   = row_found ? row_idx : '0;
    scan.col   = row_found ? col_idx : '0;
    scan.code  = row_found ? {1'b0, row_idx, 1'b0, col_idx} : kpd_pkg::NO_KEY_CODE;
  end

endmodule

`default_nettype wire

// ===== rtl/core/kpd_debounce.sv =====
// Debounce state: pending code, change time and settled code, updated once per beat.
`default_nettype none

module kpd_debounce (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          advance,
  input  wire logic [kpd_pkg::TIME_W-1:0]    now_ms,
  input  wire kpd_pkg::code_t                code,
  input  wire logic [kpd_pkg::DEB_W-1:0]     debounce_ms,
  output logic                               new_key,
  output kpd_pkg::code_t                     key_code
);

  kpd_pkg::code_t               settled_r;
  kpd_pkg::code_t               settled_nxt;
  kpd_pkg::code_t               pending_r;
  logic [kpd_pkg::TIME_W-1:0]   change_time_r;
  logic [kpd_pkg::TIME_W-1:0]   change_time_nxt;
  logic [kpd_pkg::TIME_W-1:0]   elapsed;
  logic                         fresh;

  always_comb begin
    change_time_nxt = (pending_r != code) ? now_ms : change_time_r;
    elapsed = now_ms - change_time_nxt;
    settled_nxt = settled_r;
    fresh = 1'b0;
    if ((elapsed > kpd_pkg::TIME_W'(debounce_ms)) && (settled_r != code)) begin
      settled_nxt = code;
      fresh = (code != kpd_pkg::NO_KEY_CODE);
    end
  end

  assign new_key  = fresh;
  assign key_code = settled_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settled_r     <= kpd_pkg::NO_KEY_CODE;
      pending_r     <= kpd_pkg::NO_KEY_CODE;
      change_time_r <= '0;
    end else if (advance) begin
      settled_r     <= settled_nxt;
      pending_r     <= code;
      change_time_r <= change_time_nxt;
    end
  end

  a_change_time: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (code != pending_r) |=> change_time_r == $past(now_ms))
    else $error("change time not taken from the beat that changed the code");

  a_fresh_settles: assert property (@(posedge clk) disable iff (!rst_n)
    advance && fresh |=> (settled_r != kpd_pkg::NO_KEY_CODE) &&
                         (settled_r != $past(settled_r)))
    else $error("new key reported without a settled change");

  a_no_settle_on_change: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (code != pending_r) |-> settled_nxt == settled_r)
    else $error("code settled on the beat it changed");

endmodule

`default_nettype wire

// ===== rtl/core/keypad_matrix_scan_debounce.sv =====
// Top level of the keypad matrix scanner with debounce.
`default_nettype none

// Matrix keypad scanner with debounce. Each input beat carries one scan of the
// key matrix (bit row*8+col set when pressed) and the millisecond time of that
// scan; each input beat yields exactly one result beat with the raw scanned
// key, the settled key code (0xFF for no key) and a new-key flag. One beat is
// taken per clock cycle while the result is not stalled; a beat passes from
// the input register to the result register, where it stays valid until
// it is taken. The priority encode and the debounce state update run
// combinationally between the input register and the result register.
// A stalled result holds the input register, so at most two beats are held.
// Register writes (row_count, col_count, debounce_ms) are always accepted and
// take effect for the next scan; write them only while no scan is in flight.

module keypad_matrix_scan_debounce (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kpd_in_if.sink     in_ch,
  kpd_out_if.source  out_ch,
  kpd_cfg_if.sink    cfg_ch
);

  kpd_pkg::cfg_t                 cfg_r;
  logic                          s1_valid_r;
  logic                          s1_valid_nxt;
  logic [kpd_pkg::MAP_W-1:0]     s1_map_r;
  logic [kpd_pkg::TIME_W-1:0]    s1_now_r;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  kpd_pkg::scan_t                scan_r;
  logic                          new_key_r;
  kpd_pkg::code_t                key_code_r;

  logic                          in_fire;
  logic                          s2_load;
  logic                          s1_adv;
  kpd_pkg::scan_t                scan;
  logic                          new_key;
  kpd_pkg::code_t                key_code;

  // Register writes.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_count   <= kpd_pkg::ROW_COUNT_RST;
      cfg_r.col_count   <= kpd_pkg::COL_COUNT_RST;
      cfg_r.debounce_ms <= kpd_pkg::DEBOUNCE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        kpd_pkg::REG_ROW_COUNT: begin
          cfg_r.row_count <= cfg_ch.data[kpd_pkg::COUNT_W-1:0];
        end
        kpd_pkg::REG_COL_COUNT: begin
          cfg_r.col_count <= cfg_ch.data[kpd_pkg::COUNT_W-1:0];
        end
        kpd_pkg::REG_DEBOUNCE_MS: begin
          cfg_r.debounce_ms <= cfg_ch.data[kpd_pkg::DEB_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Pipeline handshake: the result register loads when empty or drained.
  assign s2_load     = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && s2_load;
  assign in_ch.ready = !s1_valid_r || s2_load;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = s2_load ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_map_r <= in_ch.pressed_map;
      s1_now_r <= in_ch.now_ms;
    end
    if (s1_adv) begin
      scan_r     <= scan;
      new_key_r  <= new_key;
      key_code_r <= key_code;
    end
  end

  kpd_scan u_scan (
    .pressed_map (s1_map_r),
    .cfg         (cfg_r),
    .scan        (scan)
  );

  kpd_debounce u_debounce (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (s1_adv),
    .now_ms      (s1_now_r),
    .code        (scan.code),
    .debounce_ms (cfg_r.debounce_ms),
    .new_key     (new_key),
    .key_code    (key_code)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.raw_found = scan_r.found;
  assign out_ch.raw_row   = scan_r.row;
  assign out_ch.raw_col   = scan_r.col;
  assign out_ch.new_key   = new_key_r;
  assign out_ch.key_code  = key_code_r;

  a_new_key_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && new_key_r |-> key_code_r != kpd_pkg::NO_KEY_CODE)
    else $error("new key reported with the no-key code");

  a_beat_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced beat did not reach the result register");

  a_no_found_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !scan_r.found |-> (scan_r.row == '0) && (scan_r.col == '0))
    else $error("raw position set without a found key");

endmodule

`default_nettype wire
